@@ hdl/tetra_mesh_connectivity_walker_top_macros.svh @@
// ---------------------------------------------------------------------------
// Tetra mesh walker assertion macros
// Concurrent assertion shorthands; they expand to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef TETRA_MESH_CONNECTIVITY_WALKER_TOP_MACROS_SVH
`define TETRA_MESH_CONNECTIVITY_WALKER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TMCW_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tmcw assertion failed");
// next-cycle implication
`define TMCW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tmcw assertion failed");
`else
`define TMCW_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TMCW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/tmcw_pkg.sv @@
// ---------------------------------------------------------------------------
// Tetra mesh walker package
// Widths, constants and the result record shared by the walker modules.
// ---------------------------------------------------------------------------
package tmcw_pkg;

	// Largest supported edge point count
	localparam int MAX_EDGE = 64;

	localparam int EDGE_W  = 7;   // edge point count
	localparam int COORD_W = 6;   // layer, row, column
	localparam int SUB_W   = 3;   // sub-cell number
	localparam int IDX_W   = 16;  // point index
	localparam int LP_W    = 12;  // points in one layer
	localparam int CNT_W   = 18;  // tetrahedron count

	localparam logic [EDGE_W-1:0] EDGE_MIN   = EDGE_W'(2);
	localparam logic [EDGE_W-1:0] EDGE_MAX   = EDGE_W'(MAX_EDGE);
	localparam logic [EDGE_W-1:0] EDGE_RESET = EDGE_W'(2);
	// Points in layer zero at the reset edge: 2*3/2
	localparam logic [LP_W-1:0]   LP0_RESET  = LP_W'(3);

	// Sub-cell numbers of one interior column position
	localparam logic [SUB_W-1:0] SC_FIRST  = SUB_W'(0);
	localparam logic [SUB_W-1:0] SC_SECOND = SUB_W'(1);
	localparam logic [SUB_W-1:0] SC_THIRD  = SUB_W'(2);
	localparam logic [SUB_W-1:0] SC_FOURTH = SUB_W'(3);
	localparam logic [SUB_W-1:0] SC_FIFTH  = SUB_W'(4);
	localparam logic [SUB_W-1:0] SC_SIXTH  = SUB_W'(5);

	// One emitted tetrahedron
	typedef struct packed {
		logic [IDX_W-1:0] vertex_one;
		logic [IDX_W-1:0] vertex_two;
		logic [IDX_W-1:0] vertex_three;
		logic [IDX_W-1:0] vertex_four;
		logic [CNT_W-1:0] tetra_number;
		logic             final_one;
		logic             exhausted;
	} tmcw_result_t;

endpackage

@@ hdl/tmcw_core.sv @@
// ---------------------------------------------------------------------------
// Tetra mesh walker core
// Walk position registers, vertex index arithmetic and the one-step advance.
// ---------------------------------------------------------------------------
module tmcw_core import tmcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              restart,
	input  logic              cfg_we,
	input  logic [EDGE_W-1:0] cfg_data,
	output tmcw_result_t      result,
	output logic              walk_done
);

	logic [EDGE_W-1:0]  edge_q;
	logic [LP_W-1:0]    lp0_q;
	logic [COORD_W-1:0] layer_q, row_q, col_q;
	logic [SUB_W-1:0]   sub_q;
	logic [IDX_W-1:0]   base_q;
	logic [LP_W-1:0]    lp_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               done_q;

	logic [EDGE_W-1:0]  cfg_clamped;
	logic [13:0]        lp0_prod;

	logic [COORD_W-1:0] layer_c, row_c, col_c;
	logic [SUB_W-1:0]   sub_c;
	logic [IDX_W-1:0]   base_c;
	logic [LP_W-1:0]    lp_c;
	logic [CNT_W-1:0]   cnt_c;
	logic               done_c;

	logic [COORD_W-1:0] n1;
	logic [EDGE_W-1:0]  cells, nj, rows, col_p1, col_p2, row_p1, layer_p1;
	logic [LP_W-1:0]    offj;
	logic               last_col, near_end, row_end, layer_end, sub_wrap;
	logic [IDX_W-1:0]   p_a, p_b, p_c, p_d, p_e, p_f, p_g, p_h;
	logic [IDX_W-1:0]   v1, v2, v3, v4;

	// Clamp the written edge count and form the layer-zero point count
	always_comb begin
		priority if (cfg_data < EDGE_MIN) begin
			cfg_clamped = EDGE_MIN;
		end else if (cfg_data > EDGE_MAX) begin
			cfg_clamped = EDGE_MAX;
		end else begin
			cfg_clamped = cfg_data;
		end
		lp0_prod = 14'(cfg_clamped) * 14'({1'b0, cfg_clamped} + 8'd1);
	end

	// Apply a restart ahead of the step
	always_comb begin
		if (restart) begin
			layer_c = '0;
			row_c   = '0;
			col_c   = '0;
			sub_c   = SC_FIRST;
			base_c  = '0;
			lp_c    = lp0_q;
			cnt_c   = '0;
			done_c  = 1'b0;
		end else begin
			layer_c = layer_q;
			row_c   = row_q;
			col_c   = col_q;
			sub_c   = sub_q;
			base_c  = base_q;
			lp_c    = lp_q;
			cnt_c   = cnt_q;
			done_c  = done_q;
		end
	end

	// Row geometry and end-of-walk tests
	always_comb begin
		n1        = COORD_W'(edge_q - EDGE_W'(1));
		rows      = {1'b0, n1} - {1'b0, layer_c};
		cells     = rows - {1'b0, row_c};
		nj        = cells + EDGE_W'(1);
		offj      = lp_c - LP_W'(row_c);
		col_p1    = {1'b0, col_c} + EDGE_W'(1);
		col_p2    = {1'b0, col_c} + EDGE_W'(2);
		row_p1    = {1'b0, row_c} + EDGE_W'(1);
		layer_p1  = {1'b0, layer_c} + EDGE_W'(1);
		last_col  = (col_p1 >= cells);
		near_end  = (col_p2 >= cells);
		row_end   = (row_p1 >= rows);
		layer_end = (layer_p1 >= {1'b0, n1});
		sub_wrap  = near_end ? (sub_c == SC_FIFTH) : (sub_c == SC_SIXTH);
	end

	// Candidate corner indices, 1-based
	always_comb begin
		p_a = base_c + IDX_W'(1);
		p_b = base_c + IDX_W'(2);
		p_c = base_c + IDX_W'(nj) + IDX_W'(1);
		p_d = base_c + IDX_W'(nj) + IDX_W'(2);
		p_e = base_c + IDX_W'(offj) + IDX_W'(1);
		p_f = base_c + IDX_W'(offj) + IDX_W'(2);
		p_g = base_c + IDX_W'(nj) + IDX_W'(offj);
		p_h = p_g + IDX_W'(1);
	end

	// Pick the corners of the current sub-cell
	always_comb begin
		if (last_col) begin
			{v1, v2, v3, v4} = {p_a, p_b, p_c, p_e};
		end else begin
			unique case (sub_c)
				SC_FIRST:  {v1, v2, v3, v4} = {p_a, p_b, p_c, p_e};
				SC_SECOND: {v1, v2, v3, v4} = {p_b, p_d, p_c, p_e};
				SC_THIRD:  {v1, v2, v3, v4} = {p_b, p_d, p_e, p_f};
				SC_FOURTH: {v1, v2, v3, v4} = {p_c, p_d, p_g, p_e};
				SC_FIFTH:  {v1, v2, v3, v4} = {p_d, p_e, p_f, p_g};
				default:   {v1, v2, v3, v4} = {p_d, p_f, p_h, p_g};
			endcase
		end
	end

	// Drive the result; zeros when the walk is exhausted
	always_comb begin
		if (done_c) begin
			result = '0;
			result.exhausted = 1'b1;
		end else begin
			result.vertex_one   = v1;
			result.vertex_two   = v2;
			result.vertex_three = v3;
			result.vertex_four  = v4;
			result.tetra_number = cnt_c;
			result.final_one    = last_col && row_end && layer_end;
			result.exhausted    = 1'b0;
		end
	end

	assign walk_done = done_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q <= EDGE_RESET;
			lp0_q  <= LP0_RESET;
		end else if (cfg_we) begin
			edge_q <= cfg_clamped;
			lp0_q  <= lp0_prod[LP_W:1];
		end
	end

	// Advance the walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layer_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
			sub_q   <= SC_FIRST;
			base_q  <= '0;
			lp_q    <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b1;
		end else if (cfg_we) begin
			done_q <= 1'b1;
		end else if (step && !done_c) begin
			cnt_q <= cnt_c + CNT_W'(1);
			if (!last_col) begin
				layer_q <= layer_c;
				row_q   <= row_c;
				lp_q    <= lp_c;
				done_q  <= 1'b0;
				if (sub_wrap) begin
					sub_q  <= SC_FIRST;
					col_q  <= col_c + COORD_W'(1);
					base_q <= base_c + IDX_W'(1);
				end else begin
					sub_q  <= sub_c + SUB_W'(1);
					col_q  <= col_c;
					base_q <= base_c;
				end
			end else begin
				col_q <= '0;
				sub_q <= SC_FIRST;
				if (row_end) begin
					base_q  <= base_c + IDX_W'(3);
					row_q   <= '0;
					layer_q <= layer_c + COORD_W'(1);
					if (layer_end) begin
						done_q <= 1'b1;
						lp_q   <= '0;
					end else begin
						done_q <= 1'b0;
						lp_q   <= lp_c - LP_W'(edge_q - {1'b0, layer_c});
					end
				end else begin
					base_q  <= base_c + IDX_W'(2);
					row_q   <= row_c + COORD_W'(1);
					layer_q <= layer_c;
					lp_q    <= lp_c;
					done_q  <= 1'b0;
				end
			end
		end else if (step) begin
			// exhausted tick: hold everything
			done_q <= done_c;
		end
	end

endmodule

@@ hdl/tetra_mesh_connectivity_walker_top.sv @@
// ---------------------------------------------------------------------------
// Tetra mesh connectivity walker
// Streams the four point indices of each tetrahedron of a split tetrahedron.
// ---------------------------------------------------------------------------
// Each input transaction carries a restart flag and yields exactly one output
// transaction: the next tetrahedron (or the first one after a restart), or an
// exhausted marker with zero vertices once (edge_points-1)^3 tetrahedra have
// gone out. The block takes one transaction per clock while the output is not
// stalled. The result is loaded into the result register when the transaction
// moves on from the input register (input register, then result register); a
// result held in the result register stalls the input only while the input
// register is also full. The rate is set by the core updating the walk position
// on each step. Writing edge_points ends any walk in progress, so a restart
// must follow.
`include "tetra_mesh_connectivity_walker_top_macros.svh"

module tetra_mesh_connectivity_walker_top import tmcw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic [EDGE_W-1:0] cfg_data,    // edge_points
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,     // [0] restart
	// output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [87:0]       m_tdata,     // [15:0] vertex_one, [31:16] vertex_two,
	                                       // [47:32] vertex_three, [63:48] vertex_four,
	                                       // [81:64] tetra_number
	output logic              m_tlast,     // final_one
	output logic [0:0]        m_tuser      // [0] exhausted
);

	logic         v_s1, restart_s1;
	logic         v_s2;
	tmcw_result_t res_s2;
	logic         adv, step;
	tmcw_result_t result;
	logic         core_done;

	// Handshake: stage 2 moves when empty or taken, stage 1 when empty or stage 2 moves
	assign adv      = !v_s2 || m_tready;
	assign s_tready = !v_s1 || adv;
	assign step     = v_s1 && adv;

	tmcw_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.restart   (restart_s1),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.result    (result),
		.walk_done (core_done)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			restart_s1 <= s_tdata[0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= result;
		end
	end

	// Pack the output transaction
	assign m_tvalid   = v_s2;
	assign m_tdata    = {6'b0, res_s2.tetra_number, res_s2.vertex_four,
	                     res_s2.vertex_three, res_s2.vertex_two, res_s2.vertex_one};
	assign m_tlast    = res_s2.final_one;
	assign m_tuser[0] = res_s2.exhausted;

	// Checks
	`TMCW_ASSERT_IMPL(a_last_not_exhausted, clk, arst_n, m_tvalid && m_tlast, !m_tuser[0])
	`TMCW_ASSERT_IMPL(a_exhausted_zero, clk, arst_n, m_tvalid && m_tuser[0], m_tdata == '0)
	`TMCW_ASSERT_NEXT(a_final_ends_walk, clk, arst_n, step && result.final_one, core_done)
	`TMCW_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_tvalid && s_tready, v_s1)

endmodule
